FILE: rtl/core/gcc_pkg.sv
// ----------------------------------------------------------------------------
// gcc_pkg: shared codes for the connected components engine
// Opcode and result kind codes, register reset value and default sizing.
// ----------------------------------------------------------------------------
package gcc_pkg;

  // default graph size
  localparam int MAX_VERTICES_DEF = 64;

  // field widths fixed by the item format
  localparam int OPCODE_W = 2;
  localparam int VTX_W    = 6;
  localparam int KIND_W   = 2;
  localparam int LABEL_W  = 6;
  localparam int COUNT_W  = 7;

  // vertex count register reset value
  localparam logic [COUNT_W-1:0] VCOUNT_RESET = 7'd64;

  // input opcodes
  localparam logic [OPCODE_W-1:0] OP_INSERT     = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE     = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_COMPONENTS = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_UNUSED     = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RANGE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LABEL = 2'd2;

endpackage

FILE: rtl/core/graph_connected_components.sv
// ----------------------------------------------------------------------------
// graph_connected_components: adjacency matrix graph with component labeling
// Edge insert and remove as a read-modify-write of two matrix rows, and a
// depth-first component search driven by one shared find-first-set unit.
// ----------------------------------------------------------------------------
// Edge item: after both row updates, status item registered once the output is free.
// Out-of-range edge item: no row update; status item registered once output is free.
// Component request over n vertices forming c components: its run time is
//   set by the single adjacency read port and the one-bit-per-cycle search.
// One item at a time; the next item is taken once the last result is queued.
// Synchronous reset clears the graph (row valid bits) and control, and sets the count to VCOUNT_RESET.
module graph_connected_components
  import gcc_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_write,
  input  logic [COUNT_W-1:0]  cfg_data,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [VTX_W-1:0]    vertex_a,
  input  logic [VTX_W-1:0]    vertex_b,
  // output channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [KIND_W-1:0]   kind,
  output logic [VTX_W-1:0]    vertex_index,
  output logic [LABEL_W-1:0]  component_id,
  output logic [COUNT_W-1:0]  component_total,
  output logic                last
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int SP_W  = $clog2(MAX_VERTICES + 1);

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EDGE_RDA = 4'd1;
  localparam logic [3:0] S_EDGE_WRA = 4'd2;
  localparam logic [3:0] S_EDGE_RDB = 4'd3;
  localparam logic [3:0] S_EDGE_WRB = 4'd4;
  localparam logic [3:0] S_STATUS   = 4'd5;
  localparam logic [3:0] S_SCAN     = 4'd6;
  localparam logic [3:0] S_POP      = 4'd7;
  localparam logic [3:0] S_ROWRD    = 4'd8;
  localparam logic [3:0] S_EXPAND   = 4'd9;
  localparam logic [3:0] S_LRD      = 4'd10;
  localparam logic [3:0] S_LEMIT    = 4'd11;

  logic [3:0]              state;
  logic [COUNT_W-1:0]      vertex_count;
  logic [COUNT_W-1:0]      eff_count;
  logic [MAX_VERTICES-1:0] in_use;

  logic [OPCODE_W-1:0]     edge_op;
  logic [IDX_W-1:0]        edge_a;
  logic [IDX_W-1:0]        edge_b;
  logic [KIND_W-1:0]       st_kind;

  // adjacency memory with per-row valid bits
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid;
  logic                    adj_we;
  logic [IDX_W-1:0]        adj_waddr;
  logic [MAX_VERTICES-1:0] adj_wdata;
  logic                    adj_re;
  logic [IDX_W-1:0]        adj_raddr;
  logic [MAX_VERTICES-1:0] adj_rdata;
  logic                    adj_rvalid;
  logic [MAX_VERTICES-1:0] row_eff;

  // label and walk stack memories
  logic [LABEL_W-1:0]      lbl_mem [MAX_VERTICES];
  logic [LABEL_W-1:0]      lbl_rdata;
  logic [IDX_W-1:0]        stk_mem [MAX_VERTICES];
  logic [IDX_W-1:0]        stk_rdata;
  logic                    push;

  // search state
  logic [MAX_VERTICES-1:0] labeled;
  logic [SP_W-1:0]         sp;
  logic [COUNT_W-1:0]      next_label;
  logic [IDX_W-1:0]        out_idx;
  logic                    out_is_last;

  // shared find-first-set unit
  logic [MAX_VERTICES-1:0] ffs_in;
  logic                    ffs_any;
  logic [IDX_W-1:0]        ffs_idx;

  logic                    in_accept;
  logic                    out_free;
  logic                    a_bad;
  logic                    b_bad;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // effective vertex count, clamped to 1..MAX_VERTICES
  always_comb begin
    if (vertex_count == '0) begin
      eff_count = COUNT_W'(1);
    end else if (vertex_count > COUNT_W'(MAX_VERTICES)) begin
      eff_count = COUNT_W'(MAX_VERTICES);
    end else begin
      eff_count = vertex_count;
    end
  end

  // vertices in use
  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      in_use[i] = (COUNT_W'(i) < eff_count);
    end
  end

  assign a_bad = ({1'b0, vertex_a} >= eff_count);
  assign b_bad = ({1'b0, vertex_b} >= eff_count);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_RESET;
    end else if (cfg_write) begin
      vertex_count <= cfg_data;
    end
  end

  // row seen as zero until first written
  assign row_eff = adj_rvalid ? adj_rdata : '0;

  // find-first-set operand: unlabeled vertices when scanning, new neighbors when expanding
  always_comb begin
    if (state == S_SCAN) begin
      ffs_in = in_use & ~labeled;
    end else begin
      ffs_in = row_eff & in_use & ~labeled;
    end
  end

  always_comb begin
    ffs_any = |ffs_in;
    ffs_idx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (ffs_in[i]) begin
        ffs_idx = IDX_W'(i);
      end
    end
  end

  // adjacency port control
  always_comb begin
    adj_re    = 1'b0;
    adj_raddr = edge_a;
    adj_we    = 1'b0;
    adj_waddr = edge_a;
    adj_wdata = row_eff;
    case (state)
      S_EDGE_RDA: begin
        adj_re = 1'b1;
      end
      S_EDGE_RDB: begin
        adj_re    = 1'b1;
        adj_raddr = edge_b;
      end
      S_EDGE_WRA: begin
        adj_we            = 1'b1;
        adj_wdata[edge_b] = (edge_op == OP_INSERT);
      end
      S_EDGE_WRB: begin
        adj_we            = 1'b1;
        adj_waddr         = edge_b;
        adj_wdata[edge_a] = (edge_op == OP_INSERT);
      end
      S_ROWRD: begin
        adj_re    = 1'b1;
        adj_raddr = stk_rdata;
      end
      default: begin
      end
    endcase
  end

  // adjacency memory
  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    if (adj_re) begin
      adj_rdata <= adj_mem[adj_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      adj_rvalid <= 1'b0;
    end else begin
      if (adj_we) begin
        row_valid[adj_waddr] <= 1'b1;
      end
      if (adj_re) begin
        adj_rvalid <= row_valid[adj_raddr];
      end
    end
  end

  // a vertex gets labeled and pushed when scanning or expanding finds one
  assign push = ((state == S_SCAN) || (state == S_EXPAND)) && ffs_any;

  // label memory
  always_ff @(posedge clk) begin
    if (push) begin
      lbl_mem[ffs_idx] <= next_label[LABEL_W-1:0];
    end
    if (state == S_LRD) begin
      lbl_rdata <= lbl_mem[out_idx];
    end
  end

  // walk stack memory
  always_ff @(posedge clk) begin
    if (push) begin
      stk_mem[(state == S_SCAN) ? '0 : sp[IDX_W-1:0]] <= ffs_idx;
    end
    if ((state == S_POP) && (sp != '0)) begin
      stk_rdata <= stk_mem[IDX_W'(sp - SP_W'(1))];
    end
  end

  assign out_is_last = (COUNT_W'(out_idx) == (eff_count - COUNT_W'(1)));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      next_label <= '0;
      labeled    <= '0;
      sp         <= '0;
      out_idx    <= '0;
      st_kind    <= KIND_DONE;
      edge_op    <= OP_INSERT;
      edge_a     <= '0;
      edge_b     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            edge_op <= opcode;
            edge_a  <= IDX_W'(vertex_a);
            edge_b  <= IDX_W'(vertex_b);
            case (opcode)
              OP_INSERT, OP_REMOVE: begin
                if (a_bad || b_bad) begin
                  st_kind <= KIND_RANGE;
                  state   <= S_STATUS;
                end else begin
                  st_kind <= KIND_DONE;
                  state   <= S_EDGE_RDA;
                end
              end
              OP_COMPONENTS: begin
                labeled    <= '0;
                next_label <= '0;
                state      <= S_SCAN;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_EDGE_RDA: state <= S_EDGE_WRA;
        S_EDGE_WRA: state <= S_EDGE_RDB;
        S_EDGE_RDB: state <= S_EDGE_WRB;
        S_EDGE_WRB: state <= S_STATUS;
        S_STATUS: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        // start a new component at the lowest unlabeled vertex
        S_SCAN: begin
          if (ffs_any) begin
            labeled[ffs_idx] <= 1'b1;
            sp               <= SP_W'(1);
            state            <= S_POP;
          end else begin
            out_idx <= '0;
            state   <= S_LRD;
          end
        end
        // pop one vertex, or close the component when the stack is empty
        S_POP: begin
          if (sp == '0) begin
            next_label <= next_label + COUNT_W'(1);
            state      <= S_SCAN;
          end else begin
            sp    <= sp - SP_W'(1);
            state <= S_ROWRD;
          end
        end
        S_ROWRD: state <= S_EXPAND;
        // label and push one new neighbor per cycle
        S_EXPAND: begin
          if (ffs_any) begin
            labeled[ffs_idx] <= 1'b1;
            sp               <= sp + SP_W'(1);
          end else begin
            state <= S_POP;
          end
        end
        S_LRD: state <= S_LEMIT;
        S_LEMIT: begin
          if (out_free) begin
            if (out_is_last) begin
              state <= S_IDLE;
            end else begin
              out_idx <= out_idx + IDX_W'(1);
              state   <= S_LRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_STATUS) && out_free) begin
      out_valid <= 1'b1;
    end else if ((state == S_LEMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_STATUS) && out_free) begin
      kind            <= st_kind;
      vertex_index    <= '0;
      component_id    <= '0;
      component_total <= '0;
      last            <= 1'b1;
    end else if ((state == S_LEMIT) && out_free) begin
      kind            <= KIND_LABEL;
      vertex_index    <= VTX_W'(out_idx);
      component_id    <= lbl_rdata;
      component_total <= next_label;
      last            <= out_is_last;
    end
  end

endmodule
